@@ rtl/tfd_pkg.sv @@
// tfd_pkg: shared types, codes and helper functions for the telemetry frame decoder
// used by tfd_emit and telemetry_frame_decoder; depends on nothing else
package tfd_pkg;

    // fixed frame layout
    localparam int HEADER_BYTES = 12;
    localparam int MASK_W       = 16;
    // field index wide enough to hold "no more fields" for up to 16 fields
    localparam int IDX_W        = 5;

    // result kind codes
    localparam logic KIND_FIELD  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_TRUNC = 2'd2;

    // one result beat
    typedef struct packed {
        logic        kind;
        logic        run_last;
        logic [3:0]  field_index;
        logic [31:0] field_bits;
        logic [15:0] message_id;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] sequence_num;
        logic [15:0] payload_len;
        logic [15:0] presence_mask;
        logic        checksum_ok;
        logic [1:0]  status;
    } tfd_result_t;

    // work handed from the frame tracker to the result sequencer
    typedef struct packed {
        logic              head_valid;
        tfd_result_t       head;
        logic              fill_valid;
        logic [IDX_W-1:0]  fill_idx;
        logic [MASK_W-1:0] mask;
    } tfd_job_t;

    // byte size of a field by its index
    function automatic logic [2:0] field_size(logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(0) || idx == IDX_W'(1) || idx == IDX_W'(13)) ? 3'd4 : 3'd2;
    endfunction

    // first present field at or above from, or count when none is left
    function automatic logic [IDX_W-1:0] next_present(logic [MASK_W-1:0] mask,
                                                      logic [IDX_W-1:0]  from,
                                                      logic [IDX_W-1:0]  count);
        logic [IDX_W-1:0] r;
        logic             found;
        r     = count;
        found = 1'b0;
        for (int j = 0; j < MASK_W; j++)
        begin
            if (!found && IDX_W'(j) >= from && IDX_W'(j) < count && mask[j])
            begin
                r     = IDX_W'(j);
                found = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/tfd_emit.sv @@
// tfd_emit: result sequencer, holds one job and the output register
// depends on tfd_pkg
module tfd_emit
    import tfd_pkg::*;
#(
    parameter int FIELD_COUNT = 14
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  tfd_job_t    job,
    output logic        busy,
    output logic        out_valid,
    input  logic        out_stall,
    output tfd_result_t result
);

    localparam logic [IDX_W-1:0] FC = IDX_W'(FIELD_COUNT);

    logic              head_valid_reg;
    tfd_result_t       head_reg;
    logic              fill_valid_reg;
    logic [IDX_W-1:0]  fill_idx_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              out_valid_reg;
    tfd_result_t       out_reg;

    logic              job_any;
    logic              out_free;
    logic              move;
    logic [IDX_W-1:0]  fill_after;
    logic              job_last;
    tfd_result_t       cur;

    // next result taken from the job
    always_comb
    begin
        job_any    = head_valid_reg || fill_valid_reg;
        out_free   = !out_valid_reg || !out_stall;
        move       = job_any && out_free;
        fill_after = next_present(mask_reg, fill_idx_reg + IDX_W'(1), FC);
        job_last   = head_valid_reg ? !fill_valid_reg : (fill_after >= FC);
        if (head_valid_reg)
        begin
            cur = head_reg;
        end
        else
        begin
            cur             = '0;
            cur.kind        = KIND_FIELD;
            cur.field_index = fill_idx_reg[3:0];
        end
        cur.run_last = job_last;
    end

    // a new job may land when no job is held or when the last beat of the current one moves out
    assign busy = job_any && !(move && job_last);

    // job and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            fill_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (move)
            begin
                out_valid_reg <= 1'b1;
                if (head_valid_reg)
                begin
                    head_valid_reg <= 1'b0;
                end
                else if (fill_after >= FC)
                begin
                    fill_valid_reg <= 1'b0;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load)
            begin
                head_valid_reg <= job.head_valid;
                fill_valid_reg <= job.fill_valid;
            end
        end
    end

    // job and output payload
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_reg <= cur;
            if (!head_valid_reg)
            begin
                fill_idx_reg <= fill_after;
            end
        end
        if (load)
        begin
            head_reg     <= job.head;
            fill_idx_reg <= job.fill_idx;
            mask_reg     <= job.mask;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

@@ rtl/telemetry_frame_decoder.sv @@
// telemetry_frame_decoder: top level, frame tracking and field assembly
// depends on tfd_pkg and tfd_emit
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall   data_byte, frame_end
//  out      output     out_valid / out_stall kind .. status, one port per field
//
// one byte is taken per cycle while in_stall is low; its results go through the job slot
// to the output register, one beat per cycle while out_stall is low, so a byte with more
// than one result holds in_stall high while the sequencer walks the presence mask (zero-fill bursts)
// reset clears the frame state, the job and the output register
// out_stall holds the output register; the next byte is still taken while
// the job slot is free
module telemetry_frame_decoder
    import tfd_pkg::*;
#(
    parameter int FIELD_COUNT = 14
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic        run_last,
    output logic [3:0]  field_index,
    output logic [31:0] field_bits,
    output logic [15:0] message_id,
    output logic [15:0] source_port,
    output logic [15:0] dest_port,
    output logic [15:0] sequence_num,
    output logic [15:0] payload_len,
    output logic [15:0] presence_mask,
    output logic        checksum_ok,
    output logic [1:0]  status
);

    localparam logic [IDX_W-1:0] FC      = IDX_W'(FIELD_COUNT);
    localparam logic [16:0]      POS_MAX = '1;

    logic [16:0]       pos_reg, pos_next;
    logic [7:0]        xor_reg, xor_next;
    logic [15:0]       hdr_reg  [6];
    logic [15:0]       hdr_next [6];
    logic [31:0]       acc_reg, acc_next;
    logic [IDX_W-1:0]  nf_reg, nf_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              exh_reg, exh_next;

    logic              accept;
    logic              busy;
    logic              job_load;
    tfd_job_t          job;
    tfd_result_t       result;
    logic [MASK_W-1:0] new_mask;
    logic [IDX_W-1:0]  nf_cur;
    logic [IDX_W-1:0]  fill_start;
    logic [31:0]       acc_shift;
    logic [2:0]        cnt_inc;

    assign accept   = in_valid && !in_stall;
    assign in_stall = busy;

    // per-byte frame update and job build
    always_comb
    begin
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        hdr_next   = hdr_reg;
        acc_next   = acc_reg;
        nf_next    = nf_reg;
        cnt_next   = cnt_reg;
        exh_next   = exh_reg;
        job        = '0;
        new_mask   = {hdr_reg[5][7:0], data_byte};
        nf_cur     = nf_reg;
        fill_start = FC;
        acc_shift  = {acc_reg[23:0], data_byte};
        cnt_inc    = cnt_reg + 3'd1;
        job.mask   = hdr_reg[5];

        if (frame_end)
        begin
            // status beat, then back to the reset state
            job.head_valid = 1'b1;
            job.head.kind  = KIND_STATUS;
            if (pos_reg < 17'(HEADER_BYTES))
            begin
                job.head.status = STATUS_SHORT;
            end
            else
            begin
                job.head.message_id    = hdr_reg[0];
                job.head.source_port   = hdr_reg[1];
                job.head.dest_port     = hdr_reg[2];
                job.head.sequence_num  = hdr_reg[3];
                job.head.payload_len   = hdr_reg[4];
                job.head.presence_mask = hdr_reg[5];
                job.head.checksum_ok   = (xor_reg == data_byte);
                job.head.status = ({1'b0, pos_reg} < 18'(HEADER_BYTES) + {2'b0, hdr_reg[4]})
                                  ? STATUS_TRUNC : STATUS_OK;
            end
            pos_next = '0;
            xor_next = '0;
            for (int w = 0; w < 6; w++)
            begin
                hdr_next[w] = '0;
            end
            acc_next = '0;
            nf_next  = '0;
            cnt_next = '0;
            exh_next = 1'b0;
        end
        else
        begin
            if (pos_reg < 17'(HEADER_BYTES))
            begin
                // header bytes, big-endian words
                hdr_next[pos_reg[3:1]] = {hdr_reg[pos_reg[3:1]][7:0], data_byte};
                if (pos_reg == 17'(HEADER_BYTES - 1))
                begin
                    job.mask = new_mask;
                    nf_cur   = next_present(new_mask, '0, FC);
                    acc_next = '0;
                    cnt_next = '0;
                    nf_next  = nf_cur;
                    if (hdr_reg[4] == 16'd0)
                    begin
                        exh_next   = 1'b1;
                        fill_start = nf_cur;
                        nf_next    = FC;
                    end
                end
            end
            else if (!exh_reg)
            begin
                // payload byte into the current field
                if (nf_reg < FC)
                begin
                    if (cnt_inc >= field_size(nf_reg))
                    begin
                        job.head_valid       = 1'b1;
                        job.head.kind        = KIND_FIELD;
                        job.head.field_index = nf_reg[3:0];
                        job.head.field_bits  = acc_shift;
                        acc_next = '0;
                        cnt_next = '0;
                        nf_cur   = next_present(hdr_reg[5], nf_reg + IDX_W'(1), FC);
                    end
                    else
                    begin
                        acc_next = acc_shift;
                        cnt_next = cnt_inc;
                    end
                    nf_next = nf_cur;
                end
                // end of payload: zero-fill what is left
                if ({1'b0, pos_reg} >= {2'b0, hdr_reg[4]} + 18'(HEADER_BYTES - 1))
                begin
                    exh_next   = 1'b1;
                    fill_start = nf_cur;
                    nf_next    = FC;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
            end
            xor_next = xor_reg ^ data_byte;
            if (pos_reg < POS_MAX)
            begin
                pos_next = pos_reg + 17'd1;
            end
        end

        job.fill_valid = (fill_start < FC);
        job.fill_idx   = fill_start;
    end

    assign job_load = accept && (job.head_valid || job.fill_valid);

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            xor_reg <= '0;
            for (int w = 0; w < 6; w++)
            begin
                hdr_reg[w] <= '0;
            end
            acc_reg <= '0;
            nf_reg  <= '0;
            cnt_reg <= '0;
            exh_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            xor_reg <= xor_next;
            hdr_reg <= hdr_next;
            acc_reg <= acc_next;
            nf_reg  <= nf_next;
            cnt_reg <= cnt_next;
            exh_reg <= exh_next;
        end
    end

    // result sequencer
    tfd_emit #(
        .FIELD_COUNT (FIELD_COUNT)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (job_load),
        .job       (job),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign kind          = result.kind;
    assign run_last      = result.run_last;
    assign field_index   = result.field_index;
    assign field_bits    = result.field_bits;
    assign message_id    = result.message_id;
    assign source_port   = result.source_port;
    assign dest_port     = result.dest_port;
    assign sequence_num  = result.sequence_num;
    assign payload_len   = result.payload_len;
    assign presence_mask = result.presence_mask;
    assign checksum_ok   = result.checksum_ok;
    assign status        = result.status;

`ifndef ASSERT_OFF
    // the final byte returns the frame state to its start
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_end |=> pos_reg == 17'd0 && xor_reg == 8'd0 && !exh_reg)
        else $error("frame state not cleared after final byte");

    // payload can only be exhausted once the header is complete
    a_exh_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        exh_reg |-> pos_reg >= 17'(HEADER_BYTES))
        else $error("payload exhausted inside header");

    // field pointer never passes the field count
    a_nf_range: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg <= FC)
        else $error("field pointer out of range");

    // a status beat always closes its byte's results
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STATUS |-> run_last)
        else $error("status beat not marked last");
`endif

endmodule
